[design/tst_pkg.sv]
// Shared types and field widths for the transaction state tracker.
package tst_pkg;

    localparam int MSGID_W = 64;
    localparam int CMD_W   = 4;
    localparam int SLOT_W  = 4;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_ALREADY = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

endpackage

[design/tst_if.sv]
// Valid/ready channels for message headers in and tracking results out.
interface tst_req_if import tst_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic               action;
    logic [CMD_W-1:0]   cmd_flags;
    logic [MSGID_W-1:0] msgid;

    modport source (output valid, output action, output cmd_flags, output msgid, input ready);
    modport sink   (input valid, input action, input cmd_flags, input msgid, output ready);
endinterface

interface tst_rsp_if import tst_pkg::*;
    ;
    logic              valid;
    logic              ready;
    status_t           status;
    logic              matched;
    logic [SLOT_W-1:0] slot;
    logic              entry_freed;

    modport source (output valid, output status, output matched, output slot,
                    output entry_freed, input ready);
    modport sink   (input valid, input status, input matched, input slot,
                    input entry_freed, output ready);
endinterface

[design/transaction_state_tracker.sv]
// Transaction state tracker: match table of open command/reply transactions.
//
// Each transaction on req is one message header; it yields exactly one result
// on rsp, through the input register and then the result register. A new
// header is taken every cycle while rsp is not stalled: the header is
// registered, matched against all ENTRIES table entries in parallel (key,
// origin, valid), checked and the entry is updated in the same cycle that the
// result is registered, so the next header always sees the updated table.
// Each header takes a single pass through the key match and entry update.
// Valid marks clear at reset; no clearing pass is needed and the block is
// ready right after reset. slot reports the entry index modulo 16.
module transaction_state_tracker import tst_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    tst_req_if.sink       req,
    tst_rsp_if.source     rsp
);

    localparam int IDX_W = $clog2(ENTRIES);

    // Command flag bit positions
    localparam int CMD_CREATE = 0;
    localparam int CMD_DELETE = 1;
    localparam int CMD_REPLY  = 2;
    localparam int CMD_ABORT  = 3;

    // Per-side entry flags
    localparam logic [2:0] FL_CREATE = 3'b001;
    localparam logic [2:0] FL_DELETE = 3'b010;
    localparam logic [2:0] FL_REPLY  = 3'b100;

    // Message kinds as {reply, delete, create}
    localparam logic [2:0] K_NONE             = 3'b000;
    localparam logic [2:0] K_CREATE           = 3'b001;
    localparam logic [2:0] K_DELETE           = 3'b010;
    localparam logic [2:0] K_CREATE_DEL       = 3'b011;
    localparam logic [2:0] K_REPLY            = 3'b100;
    localparam logic [2:0] K_REPLY_CREATE     = 3'b101;
    localparam logic [2:0] K_REPLY_DEL        = 3'b110;
    localparam logic [2:0] K_REPLY_CREATE_DEL = 3'b111;

    // Input stage
    logic               s1_valid_reg;
    logic               s1_action_reg;
    logic [CMD_W-1:0]   s1_cmd_reg;
    logic [MSGID_W-1:0] s1_msgid_reg;

    // Table
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [MSGID_W-1:0] key_reg [ENTRIES];
    logic [MSGID_W-1:0] key_next [ENTRIES];
    logic [ENTRIES-1:0] origin_reg, origin_next;
    logic [2:0]         rx_reg [ENTRIES];
    logic [2:0]         rx_next [ENTRIES];
    logic [2:0]         tx_reg [ENTRIES];
    logic [2:0]         tx_next [ENTRIES];

    // Result stage
    logic              out_valid_reg;
    status_t           status_reg, status_next;
    logic              matched_reg;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              freed_reg, freed_next;

    logic adv;
    logic in_ready;
    logic upd;

    // Lookup
    logic               origin;
    logic [ENTRIES-1:0] hit_vec, hit_oh, free_vec, free_oh;
    logic               hit_any, free_any;
    logic [IDX_W-1:0]   hit_idx, free_idx;
    logic [2:0]         own_flags, other_flags;

    // Decision
    logic [2:0]       kind;
    logic             ent_valid;
    logic [IDX_W-1:0] ent_idx;
    logic             do_open, do_rc, do_del;
    logic [2:0]       own_new;
    logic [IDX_W+3:0] slot_ext;

    assign adv      = !out_valid_reg || rsp.ready;
    assign in_ready = !s1_valid_reg || adv;
    assign upd      = adv && s1_valid_reg;
    assign req.ready = in_ready;

    // Capture the incoming header
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && req.valid)
        begin
            s1_action_reg <= req.action;
            s1_cmd_reg    <= req.cmd_flags;
            s1_msgid_reg  <= req.msgid;
        end
    end

    // Match all entries and pick the lowest hit and lowest free index
    assign origin   = s1_action_reg ^ s1_cmd_reg[CMD_REPLY];
    assign free_vec = ~valid_reg;
    assign hit_oh   = hit_vec & (~hit_vec + ENTRIES'(1));
    assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));
    assign hit_any  = |hit_vec;
    assign free_any = |free_vec;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == s1_msgid_reg)
                         && (origin_reg[i] == origin);
        end
    end

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_idx  = hit_idx  | (hit_oh[i]  ? IDX_W'(i) : '0);
            free_idx = free_idx | (free_oh[i] ? IDX_W'(i) : '0);
        end
    end

    assign own_flags   = s1_action_reg ? tx_reg[hit_idx] : rx_reg[hit_idx];
    assign other_flags = s1_action_reg ? rx_reg[hit_idx] : tx_reg[hit_idx];
    assign kind = {s1_cmd_reg[CMD_REPLY], s1_cmd_reg[CMD_DELETE], s1_cmd_reg[CMD_CREATE]};

    // Check the header against the entry and decide the update
    always_comb
    begin
        status_next = ST_OK;
        ent_valid   = hit_any;
        ent_idx     = hit_idx;
        do_open     = 1'b0;
        do_rc       = 1'b0;
        do_del      = 1'b0;
        freed_next  = 1'b0;
        if (s1_cmd_reg[CMD_CREATE] || s1_cmd_reg[CMD_DELETE] || s1_cmd_reg[CMD_ABORT])
        begin
            unique case (kind)
                K_CREATE, K_CREATE_DEL:
                begin
                    if (hit_any)
                    begin
                        status_next = ST_INVALID;
                    end
                    else if (!free_any)
                    begin
                        status_next = ST_FULL;
                        ent_valid   = 1'b0;
                    end
                    else
                    begin
                        ent_valid = 1'b1;
                        ent_idx   = free_idx;
                        do_open   = 1'b1;
                    end
                end
                K_DELETE, K_REPLY_DEL:
                begin
                    if (!hit_any || !own_flags[CMD_CREATE])
                    begin
                        status_next = s1_cmd_reg[CMD_ABORT] ? ST_ALREADY : ST_INVALID;
                    end
                end
                K_REPLY_CREATE, K_REPLY_CREATE_DEL:
                begin
                    if (!hit_any)
                    begin
                        status_next = ST_INVALID;
                    end
                    else
                    begin
                        do_rc = 1'b1;
                    end
                end
                K_NONE, K_REPLY:
                begin
                    if (s1_cmd_reg[CMD_ABORT] && (!hit_any || !own_flags[CMD_CREATE]))
                    begin
                        status_next = ST_ALREADY;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase

            // Record the half-close; release once the far side closed too
            if (status_next == ST_OK && s1_cmd_reg[CMD_DELETE] && ent_valid)
            begin
                do_del     = 1'b1;
                freed_next = !do_open && other_flags[CMD_DELETE];
            end
        end
    end

    assign slot_ext  = {4'b0, ent_idx};
    assign slot_next = ent_valid ? slot_ext[SLOT_W-1:0] : '0;

    always_comb
    begin
        if (do_open)
        begin
            own_new = FL_CREATE | (do_del ? FL_DELETE : 3'b000);
        end
        else if (do_rc)
        begin
            own_new = FL_CREATE | FL_REPLY | (do_del ? FL_DELETE : 3'b000);
        end
        else
        begin
            own_new = own_flags | (do_del ? FL_DELETE : 3'b000);
        end
    end

    // Build the next table contents
    always_comb
    begin
        valid_next  = valid_reg;
        origin_next = origin_reg;
        key_next    = key_reg;
        rx_next     = rx_reg;
        tx_next     = tx_reg;
        if (upd)
        begin
            if (do_open)
            begin
                valid_next[free_idx]  = 1'b1;
                key_next[free_idx]    = s1_msgid_reg;
                origin_next[free_idx] = s1_action_reg;
                if (s1_action_reg)
                begin
                    tx_next[free_idx] = own_new;
                    rx_next[free_idx] = FL_REPLY;
                end
                else
                begin
                    rx_next[free_idx] = own_new;
                    tx_next[free_idx] = FL_REPLY;
                end
            end
            else if (do_rc || do_del)
            begin
                if (s1_action_reg)
                begin
                    tx_next[hit_idx] = own_new;
                end
                else
                begin
                    rx_next[hit_idx] = own_new;
                end
                if (freed_next)
                begin
                    valid_next[hit_idx] = 1'b0;
                end
            end
        end
    end

    // Hold the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        origin_reg <= origin_next;
        key_reg    <= key_next;
        rx_reg     <= rx_next;
        tx_reg     <= tx_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            status_reg  <= status_next;
            matched_reg <= hit_any;
            slot_reg    <= slot_next;
            freed_reg   <= freed_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.matched     = matched_reg;
    assign rsp.slot        = slot_reg;
    assign rsp.entry_freed = freed_reg;

`ifndef SYNTHESIS
    // A release only follows a clean delete of an existing entry
    a_freed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && freed_reg) |-> (status_reg == ST_OK && matched_reg))
        else $error("entry released on a failed or unmatched transaction");

    // A full table reports no entry
    a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FULL) |-> (slot_reg == '0 && !matched_reg))
        else $error("table-full result carries an entry");

    // The table only changes when a transaction moves to the result stage
    a_table_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !upd |=> $stable(valid_reg))
        else $error("valid marks changed without a transaction");

    // At most one entry opens or closes per transaction
    a_one_change: assert property (@(posedge clk) disable iff (!rst_n)
        upd |=> $onehot0(valid_reg ^ $past(valid_reg)))
        else $error("more than one entry changed in one transaction");
`endif

endmodule
